### hdl/cptp_pkg.sv
package cptp_pkg;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INTERVAL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POINT    = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] point_index;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  segment;
    logic [DATA_W-1:0] distance;
    logic [DATA_W-1:0] distance_max;
    logic [DATA_W-1:0] total;
    logic [DATA_W-1:0] total_peak;
    logic [DATA_W-1:0] period_peak;
    logic              last;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic acc;
    logic walk;
    logic walk_first;
    logic peak;
    logic emit;
    logic emit_last;
  } ctl_t;

endpackage

### hdl/cptp_ctrl.sv
module cptp_ctrl #(
  parameter int NUM_POINTS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cptp_pkg::CMD_W-1:0]      command,
  output logic                            busy,
  output cptp_pkg::ctl_t                  ctl,
  output logic [$clog2((NUM_POINTS < 8) ? NUM_POINTS : 8)-1:0] walk_idx,
  output logic [$clog2(NUM_POINTS)-1:0]   emit_idx
);
  import cptp_pkg::*;

  localparam int PT = (NUM_POINTS < 8) ? NUM_POINTS : 8;
  localparam int PW = $clog2(PT);
  localparam int EW = $clog2(NUM_POINTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_PEAK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] widx_r, widx_nxt;
  logic [EW-1:0] eidx_r, eidx_nxt;
  logic          acc;
  logic          fin;

  assign busy = (state_r != ST_IDLE);
  assign acc  = start && (state_r == ST_IDLE);
  assign fin  = acc && ((command == CMD_START) || (command == CMD_STOP));

  always_comb begin
    state_nxt = state_r;
    widx_nxt  = widx_r;
    eidx_nxt  = eidx_r;
    case (state_r)
      ST_IDLE: begin
        if (fin) begin
          state_nxt = ST_WALK;
          widx_nxt  = '0;
        end
      end
      ST_WALK: begin
        if (widx_r == PW'(PT - 1)) begin
          state_nxt = ST_PEAK;
        end else begin
          widx_nxt = widx_r + PW'(1);
        end
      end
      ST_PEAK: begin
        state_nxt = ST_EMIT;
        eidx_nxt  = '0;
      end
      ST_EMIT: begin
        if (eidx_r == EW'(NUM_POINTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          eidx_nxt = eidx_r + EW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      widx_r  <= '0;
      eidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      widx_r  <= widx_nxt;
      eidx_r  <= eidx_nxt;
    end
  end

  always_comb begin
    ctl.acc        = acc;
    ctl.walk       = (state_r == ST_WALK);
    ctl.walk_first = (widx_r == '0);
    ctl.peak       = (state_r == ST_PEAK);
    ctl.emit       = (state_r == ST_EMIT);
    ctl.emit_last  = (eidx_r == EW'(NUM_POINTS - 1));
  end

  assign walk_idx = widx_r;
  assign emit_idx = eidx_r;

endmodule

### hdl/cptp_datapath.sv
module cptp_datapath #(
  parameter int NUM_POINTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cptp_pkg::in_word_t            in_word,
  input  cptp_pkg::ctl_t                ctl,
  input  logic [$clog2((NUM_POINTS < 8) ? NUM_POINTS : 8)-1:0] walk_idx,
  input  logic [$clog2(NUM_POINTS)-1:0] emit_idx,
  output logic                          out_strobe,
  output cptp_pkg::out_word_t           out_word
);
  import cptp_pkg::*;

  // only checkpoints below min(NUM_POINTS,8) can be marked; higher entries stay zero forever
  localparam int PT = (NUM_POINTS < 8) ? NUM_POINTS : 8;
  localparam int PW = $clog2(PT);

  logic [DATA_W-1:0] tick_r, tick_nxt;
  logic              run_r, run_nxt;
  logic [DATA_W-1:0] pt_r [PT];
  logic [DATA_W-1:0] pt_nxt [PT];
  logic [DATA_W-1:0] ip_r [PT];
  logic [DATA_W-1:0] ip_nxt [PT];
  logic [DATA_W-1:0] dist_r [PT];
  logic [DATA_W-1:0] dist_nxt [PT];
  logic [DATA_W-1:0] smax_r [PT];
  logic [DATA_W-1:0] smax_nxt [PT];
  logic [DATA_W-1:0] total_r, total_nxt;
  logic [DATA_W-1:0] tpeak_r, tpeak_nxt;
  logic [DATA_W-1:0] ppeak_r, ppeak_nxt;
  logic [DATA_W-1:0] fval_r, fval_nxt;
  logic [DATA_W-1:0] prev_r, prev_nxt;
  logic              brk_r, brk_nxt;
  logic              ov_r, ov_nxt;
  out_word_t         ow_r, ow_nxt;

  logic              ok;
  logic [PW-1:0]     pidx;
  logic [DATA_W-1:0] cur;
  logic              brk_now;
  logic [DATA_W-1:0] dist_new;
  logic              in_range;
  logic [PW-1:0]     eidx;

  assign ok       = int'(in_word.point_index) < NUM_POINTS;
  assign pidx     = in_word.point_index[PW-1:0];
  assign cur      = pt_r[walk_idx];
  assign brk_now  = !ctl.walk_first && (brk_r || (cur < prev_r));
  assign dist_new = ctl.walk_first ? cur :
                    (brk_now ? dist_r[walk_idx] : cur - prev_r);
  assign in_range = int'(emit_idx) < PT;
  assign eidx     = emit_idx[PW-1:0];

  always_comb begin
    tick_nxt  = tick_r;
    run_nxt   = run_r;
    pt_nxt    = pt_r;
    ip_nxt    = ip_r;
    dist_nxt  = dist_r;
    smax_nxt  = smax_r;
    total_nxt = total_r;
    tpeak_nxt = tpeak_r;
    ppeak_nxt = ppeak_r;
    fval_nxt  = fval_r;
    prev_nxt  = prev_r;
    brk_nxt   = brk_r;
    ov_nxt    = 1'b0;
    ow_nxt    = ow_r;

    if (ctl.acc) begin
      case (in_word.command)
        CMD_TICK: begin
          if (run_r) begin
            tick_nxt = tick_r + DATA_W'(1);
          end
        end
        CMD_START: begin
          fval_nxt = tick_r;
          if (tick_r > ppeak_r) begin
            ppeak_nxt = tick_r;
          end
          tick_nxt = '0;
          run_nxt  = 1'b1;
        end
        CMD_STOP: begin
          fval_nxt = '0;
          run_nxt  = 1'b0;
        end
        CMD_INTERVAL: begin
          ow_nxt.value = '0;
          if (ok) begin
            pt_nxt[pidx] = tick_r;
            ip_nxt[pidx] = tick_r;
            ow_nxt.value = tick_r - ip_r[pidx];
          end
          ov_nxt              = 1'b1;
          ow_nxt.segment      = in_word.point_index;
          ow_nxt.distance     = '0;
          ow_nxt.distance_max = '0;
          ow_nxt.total        = total_r;
          ow_nxt.total_peak   = tpeak_r;
          ow_nxt.period_peak  = ppeak_r;
          ow_nxt.last         = 1'b1;
        end
        CMD_POINT: begin
          if (ok) begin
            pt_nxt[pidx] = tick_r;
          end
          ov_nxt              = 1'b1;
          ow_nxt.value        = tick_r;
          ow_nxt.segment      = in_word.point_index;
          ow_nxt.distance     = '0;
          ow_nxt.distance_max = '0;
          ow_nxt.total        = total_r;
          ow_nxt.total_peak   = tpeak_r;
          ow_nxt.period_peak  = ppeak_r;
          ow_nxt.last         = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // one checkpoint per cycle; a break freezes distances and total
    if (ctl.walk) begin
      brk_nxt = brk_now;
      if (!brk_now) begin
        dist_nxt[walk_idx] = dist_new;
        prev_nxt           = cur;
        total_nxt          = cur;
      end
      if (smax_r[walk_idx] < dist_new) begin
        smax_nxt[walk_idx] = dist_new;
      end
    end

    if (ctl.peak) begin
      if (tpeak_r < total_r) begin
        tpeak_nxt = total_r;
      end
    end

    if (ctl.emit) begin
      ov_nxt              = 1'b1;
      ow_nxt.value        = fval_r;
      ow_nxt.segment      = IDX_W'(emit_idx);
      ow_nxt.distance     = in_range ? dist_r[eidx] : '0;
      ow_nxt.distance_max = in_range ? smax_r[eidx] : '0;
      ow_nxt.total        = total_r;
      ow_nxt.total_peak   = tpeak_r;
      ow_nxt.period_peak  = ppeak_r;
      ow_nxt.last         = ctl.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      run_r   <= 1'b0;
      for (int i = 0; i < PT; i++) begin
        pt_r[i]   <= '0;
        ip_r[i]   <= '0;
        dist_r[i] <= '0;
        smax_r[i] <= '0;
      end
      total_r <= '0;
      tpeak_r <= '0;
      ppeak_r <= '0;
      brk_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      tick_r  <= tick_nxt;
      run_r   <= run_nxt;
      pt_r    <= pt_nxt;
      ip_r    <= ip_nxt;
      dist_r  <= dist_nxt;
      smax_r  <= smax_nxt;
      total_r <= total_nxt;
      tpeak_r <= tpeak_nxt;
      ppeak_r <= ppeak_nxt;
      brk_r   <= brk_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fval_r <= fval_nxt;
    prev_r <= prev_nxt;
    ow_r   <= ow_nxt;
  end

  assign out_strobe = ov_r;
  assign out_word   = ow_r;

endmodule

### hdl/checkpoint_timing_profiler_unit.sv
// channel   direction  ports                  word
// input     in         start, busy, in_word   command, point_index
// result    out        out_strobe, out_word   value .. last, one cycle each
//
// tick and mark words are taken every cycle while busy is low; a mark result shows in the next cycle
// start/stop raise busy while the checkpoint table is walked one entry a cycle,
// the total peak is updated in the peak state, then one result a cycle leaves
// the output register, the last as busy drops
// the receiver cannot stall, so out_strobe is never held back
// rst_n is synchronous and clears the counter, all tables and the peaks
module checkpoint_timing_profiler_unit #(
  parameter int NUM_POINTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cptp_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output cptp_pkg::out_word_t out_word
);
  import cptp_pkg::*;

  localparam int PT = (NUM_POINTS < 8) ? NUM_POINTS : 8;
  localparam int PW = $clog2(PT);
  localparam int EW = $clog2(NUM_POINTS);

  ctl_t          ctl;
  logic [PW-1:0] walk_idx;
  logic [EW-1:0] emit_idx;

  cptp_ctrl #(
    .NUM_POINTS(NUM_POINTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .command  (in_word.command),
    .busy     (busy),
    .ctl      (ctl),
    .walk_idx (walk_idx),
    .emit_idx (emit_idx)
  );

  cptp_datapath #(
    .NUM_POINTS(NUM_POINTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .ctl        (ctl),
    .walk_idx   (walk_idx),
    .emit_idx   (emit_idx),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
